### src/mailbox_message_pool_top_defines.svh
// ----------------------------------------------------------------------------
// mailbox_message_pool_top_defines.svh
// Assertion macros for the mailbox message pool. Empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef MAILBOX_MESSAGE_POOL_TOP_DEFINES_SVH
`define MAILBOX_MESSAGE_POOL_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property, sampled on clk, off during reset.
`define MBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Same-cycle implication.
`define MBP_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MBP_ASSERT(lbl, prop, msg)
`define MBP_IMPLIES(lbl, ante, cons, msg)
`endif

`endif

### src/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// Constants, types and codes of the mailbox message pool.
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int POOL_DEPTH    = 16;
    localparam int MAILBOX_COUNT = 16;
    localparam int PAYLOAD_BITS  = 64;

    localparam int IDX_W    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int OCC_W    = $clog2(POOL_DEPTH + 1);
    localparam int STAMP_W  = 32;
    localparam int BOX_W    = 4;
    localparam int SRC_W    = 5;
    localparam int KIND_W   = 8;
    localparam int DATA_W   = 64;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (SRC_W + KIND_W + DATA_W);

    typedef enum logic
    {
        OP_SEND,
        OP_RECEIVE
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_SENT,
        ST_RECEIVED,
        ST_POOL_FULL,
        ST_NO_MESSAGE
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SEND_SCAN,
        S_RECV_SCAN,
        S_RECV_LAST,
        S_RECV_DONE,
        S_RESP
    } state_t;

    typedef struct packed
    {
        logic [KIND_W-1:0]       kind;
        logic [SRC_W-1:0]        origin;
        logic [BOX_W-1:0]        target;
        logic [PAYLOAD_BITS-1:0] data;
        logic [STAMP_W-1:0]      stamp;
    } slot_t;

endpackage

### src/mailbox_message_pool_top.sv
// ----------------------------------------------------------------------------
// mailbox_message_pool_top
// Flow: a stored send walks the slot valid bits next-fit from the last slot filled,
//   one slot a cycle, and writes the first free slot that it finds.
// Refused or zero-kind sends skip the walk. Receive: one slot read a cycle, all slots.
// One item at a time (s_tready only while idle); the next item is taken while
//   a result waits at m_*. Reset: asynchronous, active low; empties the pool.
// ----------------------------------------------------------------------------
`include "mailbox_message_pool_top_defines.svh"

module mailbox_message_pool_top import mbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // mailbox[3:0], sender[8:4], match_any[9], wanted_source[14:10],
    // msg_kind[22:15], payload_in[86:23], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // opcode[0]
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // got_source[4:0], got_kind[12:5], payload_out[76:13], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]             m_tuser
);

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic [BOX_W-1:0]  in_box;
    logic [SRC_W-1:0]  in_sender;
    logic              in_any;
    logic [SRC_W-1:0]  in_want;
    logic [KIND_W-1:0] in_kind;
    logic [DATA_W-1:0] in_payload;
    opcode_t           in_op;
    logic              in_accept;

    assign in_box     = s_tdata[3:0];
    assign in_sender  = s_tdata[8:4];
    assign in_any     = s_tdata[9];
    assign in_want    = s_tdata[14:10];
    assign in_kind    = s_tdata[22:15];
    assign in_payload = s_tdata[86:23];
    assign in_op      = opcode_t'(s_tuser[0]);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;   // walk / read address
    logic [IDX_W-1:0]        scan_ptr_reg, scan_ptr_next;   // next-fit start
    logic [OCC_W-1:0]        occ_reg, occ_next;
    logic [STAMP_W-1:0]      arrival_reg, arrival_next;
    logic [POOL_DEPTH-1:0]   valid_reg, valid_next;         // slot holds a message

    // latched request
    logic [BOX_W-1:0]        req_box_reg, req_box_next;
    logic [SRC_W-1:0]        req_src_reg, req_src_next;
    logic                    req_any_reg, req_any_next;
    logic [SRC_W-1:0]        req_want_reg, req_want_next;
    logic [KIND_W-1:0]       req_kind_reg, req_kind_next;
    logic [PAYLOAD_BITS-1:0] req_data_reg, req_data_next;

    // slot memory, one synchronous read port
    slot_t                   slot_mem [POOL_DEPTH];
    slot_t                   rd_data_reg;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    rd_live_reg, rd_live_next;
    logic                    wr_en;
    slot_t                   wr_slot;

    // running best candidate of a receive
    logic                    best_found_reg, best_found_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [STAMP_W-1:0]      best_age_reg, best_age_next;
    logic [SRC_W-1:0]        best_src_reg, best_src_next;
    logic [KIND_W-1:0]       best_kind_reg, best_kind_next;
    logic [PAYLOAD_BITS-1:0] best_data_reg, best_data_next;

    // pending result, then output register
    status_t                 res_status_reg, res_status_next;
    logic [SRC_W-1:0]        res_src_reg, res_src_next;
    logic [KIND_W-1:0]       res_kind_reg, res_kind_next;
    logic [DATA_W-1:0]       res_data_reg, res_data_next;

    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [SRC_W-1:0]        out_src_reg, out_src_next;
    logic [KIND_W-1:0]       out_kind_reg, out_kind_next;
    logic [DATA_W-1:0]       out_data_reg, out_data_next;

    logic                    out_free;
    logic                    box_bad;
    logic                    pool_full;
    logic                    last_idx;
    logic [IDX_W-1:0]        idx_inc;
    logic                    cand_match;
    logic [STAMP_W-1:0]      cand_age;
    logic                    cand_take;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign box_bad   = 32'(in_box) >= 32'(MAILBOX_COUNT);
    assign pool_full = 32'(occ_reg) >= 32'(POOL_DEPTH);
    assign last_idx  = (32'(scan_idx_reg) == 32'(POOL_DEPTH - 1));
    assign idx_inc   = last_idx ? '0 : scan_idx_reg + IDX_W'(1);

    // Candidate check on the slot read last cycle. Age counts back from the
    // arrival counter, so the order holds across counter wrap.
    assign cand_match = valid_reg[rd_idx_reg]
                        && (rd_data_reg.target == req_box_reg)
                        && (req_any_reg || (rd_data_reg.origin == req_want_reg));
    assign cand_age   = arrival_reg - rd_data_reg.stamp;
    assign cand_take  = rd_live_reg && cand_match
                        && (!best_found_reg || (cand_age > best_age_reg));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_op == OP_RECEIVE)
                        state_next = box_bad ? S_RESP : S_RECV_SCAN;
                    else if ((in_kind == '0) || box_bad || pool_full)
                        state_next = S_RESP;
                    else
                        state_next = S_SEND_SCAN;
                end
            end
            S_SEND_SCAN:
            begin
                if (!valid_reg[scan_idx_reg])
                    state_next = S_RESP;
            end
            S_RECV_SCAN:
            begin
                if (last_idx)
                    state_next = S_RECV_LAST;
            end
            S_RECV_LAST: state_next = S_RECV_DONE;
            S_RECV_DONE: state_next = S_RESP;
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        scan_idx_next   = scan_idx_reg;
        scan_ptr_next   = scan_ptr_reg;
        occ_next        = occ_reg;
        arrival_next    = arrival_reg;
        valid_next      = valid_reg;
        req_box_next    = req_box_reg;
        req_src_next    = req_src_reg;
        req_any_next    = req_any_reg;
        req_want_next   = req_want_reg;
        req_kind_next   = req_kind_reg;
        req_data_next   = req_data_reg;
        rd_idx_next     = scan_idx_reg;
        rd_live_next    = (state_reg == S_RECV_SCAN);
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_age_next   = best_age_reg;
        best_src_next   = best_src_reg;
        best_kind_next  = best_kind_reg;
        best_data_next  = best_data_reg;
        res_status_next = res_status_reg;
        res_src_next    = res_src_reg;
        res_kind_next   = res_kind_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_src_next    = out_src_reg;
        out_kind_next   = out_kind_reg;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_slot.kind    = req_kind_reg;
        wr_slot.origin  = req_src_reg;
        wr_slot.target  = req_box_reg;
        wr_slot.data    = req_data_reg;
        wr_slot.stamp   = arrival_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_box_next    = in_box;
                    req_src_next    = in_sender;
                    req_any_next    = in_any;
                    req_want_next   = in_want;
                    req_kind_next   = in_kind;
                    req_data_next   = PAYLOAD_BITS'(in_payload);
                    best_found_next = 1'b0;
                    res_src_next    = '0;
                    res_kind_next   = '0;
                    res_data_next   = '0;
                    if (in_op == OP_RECEIVE)
                    begin
                        scan_idx_next   = '0;
                        res_status_next = ST_NO_MESSAGE;
                    end
                    else
                    begin
                        scan_idx_next   = scan_ptr_reg;
                        // zero kind is a silent no-op that still reports sent
                        res_status_next = (in_kind == '0) ? ST_SENT : ST_POOL_FULL;
                    end
                end
            end
            S_SEND_SCAN:
            begin
                // occupancy below depth guarantees a free slot on this walk
                if (!valid_reg[scan_idx_reg])
                begin
                    wr_en                     = 1'b1;
                    valid_next[scan_idx_reg]  = 1'b1;
                    scan_ptr_next             = scan_idx_reg;
                    arrival_next              = arrival_reg + STAMP_W'(1);
                    occ_next                  = occ_reg + OCC_W'(1);
                    res_status_next           = ST_SENT;
                end
                else
                begin
                    scan_idx_next = idx_inc;
                end
            end
            S_RECV_SCAN, S_RECV_LAST:
            begin
                if (state_reg == S_RECV_SCAN)
                    scan_idx_next = idx_inc;
                if (cand_take)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_age_next   = cand_age;
                    best_src_next   = rd_data_reg.origin;
                    best_kind_next  = rd_data_reg.kind;
                    best_data_next  = rd_data_reg.data;
                end
            end
            S_RECV_DONE:
            begin
                if (best_found_reg)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                    occ_next                 = occ_reg - OCC_W'(1);
                    res_status_next          = ST_RECEIVED;
                    res_src_next             = best_src_reg;
                    res_kind_next            = best_kind_reg;
                    res_data_next            = DATA_W'(best_data_reg);
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_src_next    = res_src_reg;
                    out_kind_next   = res_kind_reg;
                    out_data_next   = res_data_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Slot memory: write in a send, read every cycle. Send and receive never
    // overlap, so no read that a receive uses meets a write to the same slot.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[scan_idx_reg] <= wr_slot;
        rd_data_reg <= slot_mem[scan_idx_reg];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_idx_reg   <= '0;
            scan_ptr_reg   <= '0;
            occ_reg        <= '0;
            arrival_reg    <= '0;
            valid_reg      <= '0;
            rd_live_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            scan_ptr_reg   <= scan_ptr_next;
            occ_reg        <= occ_next;
            arrival_reg    <= arrival_next;
            valid_reg      <= valid_next;
            rd_live_reg    <= rd_live_next;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        req_box_reg    <= req_box_next;
        req_src_reg    <= req_src_next;
        req_any_reg    <= req_any_next;
        req_want_reg   <= req_want_next;
        req_kind_reg   <= req_kind_next;
        req_data_reg   <= req_data_next;
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_age_reg   <= best_age_next;
        best_src_reg   <= best_src_next;
        best_kind_reg  <= best_kind_next;
        best_data_reg  <= best_data_next;
        res_status_reg <= res_status_next;
        res_src_reg    <= res_src_next;
        res_kind_reg   <= res_kind_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_src_reg    <= out_src_next;
        out_kind_reg   <= out_kind_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_data_reg, out_kind_reg, out_src_reg};
    assign m_tuser  = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MBP_ASSERT(a_occ_matches_valid, ($countones(valid_reg) == 32'(occ_reg)), "occupancy out of step with valid bits")
    `MBP_IMPLIES(a_send_has_room, (state_reg == S_SEND_SCAN), !pool_full, "send walk with a full pool")
    `MBP_IMPLIES(a_recv_kind_nonzero, (out_valid_reg && (out_status_reg == ST_RECEIVED)), (out_kind_reg != '0), "received message with zero kind")
    `MBP_IMPLIES(a_fail_fields_zero, (out_valid_reg && (out_status_reg != ST_RECEIVED)), ((out_src_reg == '0) && (out_kind_reg == '0) && (out_data_reg == '0)), "failed operation returns data")

endmodule
